>>> src/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes of the priority ready queue
// Opcodes, status codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

  typedef struct packed {
    logic              ins_en;
    logic              rem_en;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
  } cell_ctrl_t;

endpackage

>>> src/prq_cell.sv
// ----------------------------------------------------------------------------
// prq_cell: one position of the sorted queue
// Holds one entry; on insert keeps, takes the new entry or takes the left
// neighbor's entry; on remove takes the right neighbor's entry at or behind a match.
// ----------------------------------------------------------------------------
module prq_cell
  import prq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic              prev_valid,
  input  logic              prev_le,
  input  logic [SLOT_W-1:0] prev_slot,
  input  logic [PRIO_W-1:0] prev_prio,
  input  logic              nbr_valid,
  input  logic [SLOT_W-1:0] nbr_slot,
  input  logic [PRIO_W-1:0] nbr_prio,
  input  logic              found_in,
  output logic              found_out,
  output logic              le,
  output logic              valid,
  output logic [SLOT_W-1:0] slot,
  output logic [PRIO_W-1:0] prio,
  output logic              valid_next,
  output logic [SLOT_W-1:0] slot_next,
  output logic [PRIO_W-1:0] prio_next
);

  logic match;

  assign match     = valid && (slot == ctrl.slot);
  assign found_out = found_in | match;
  assign le        = valid && (prio <= ctrl.prio);

  always_comb begin
    valid_next = valid;
    slot_next  = slot;
    prio_next  = prio;
    if (ctrl.ins_en && !le) begin
      if (prev_le) begin
        valid_next = 1'b1;
        slot_next  = ctrl.slot;
        prio_next  = ctrl.prio;
      end else begin
        valid_next = prev_valid;
        slot_next  = prev_slot;
        prio_next  = prev_prio;
      end
    end else if (ctrl.rem_en && found_out) begin
      valid_next = nbr_valid;
      slot_next  = nbr_slot;
      prio_next  = nbr_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    slot <= slot_next;
    prio <= prio_next;
  end

endmodule

>>> src/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_ready_queue: stable sorted ready queue of task slots
// Response: a request's response is registered in the cycle after acceptance.
// Throughput: one request per cycle while req_stall is low; the compare and shift
// of all cells and the match chain across them are worked out combinationally.
// Reset: synchronous; the queue is empty and no response is pending.
// ----------------------------------------------------------------------------
module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [OP_W-1:0]     opcode,
  input  logic [SLOT_W-1:0]   slot_id,
  input  logic [PRIO_W-1:0]   task_priority,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                head_valid,
  output logic [SLOT_W-1:0]   head_slot,
  output logic [PRIO_W-1:0]   head_priority,
  output logic [STATUS_W-1:0] op_status,
  output logic [COUNT_W-1:0]  entry_count
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              found;
  logic              full;
  logic              empty;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [STATUS_W-1:0] status_next;
  logic [CW+COUNT_W-1:0] count_ext;

  logic              c_valid      [MAX_ENTRIES];
  logic [SLOT_W-1:0] c_slot       [MAX_ENTRIES];
  logic [PRIO_W-1:0] c_prio       [MAX_ENTRIES];
  logic              c_le         [MAX_ENTRIES];
  logic              c_found      [MAX_ENTRIES];
  logic              c_valid_next [MAX_ENTRIES];
  logic [SLOT_W-1:0] c_slot_next  [MAX_ENTRIES];
  logic [PRIO_W-1:0] c_prio_next  [MAX_ENTRIES];

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign found     = c_found[MAX_ENTRIES-1];
  assign full      = c_valid[MAX_ENTRIES-1];
  assign empty     = ~c_valid[0];

  always_comb begin
    ctrl.slot   = slot_id;
    ctrl.prio   = task_priority;
    ctrl.ins_en = 1'b0;
    ctrl.rem_en = 1'b0;
    count_next  = count;
    status_next = ST_OK;
    case (opcode)
      OP_INSERT: begin
        if (found) begin
          status_next = ST_DUPLICATE;
        end else if (!full) begin
          ctrl.ins_en = accept;
          count_next  = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          ctrl.rem_en = accept;
          count_next  = count - CW'(1);
        end
      end
      OP_QUERY: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic              prev_valid;
    logic              prev_le;
    logic [SLOT_W-1:0] prev_slot;
    logic [PRIO_W-1:0] prev_prio;
    logic              nbr_valid;
    logic [SLOT_W-1:0] nbr_slot;
    logic [PRIO_W-1:0] nbr_prio;
    logic              found_in;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b0;
      assign prev_le    = 1'b1;
      assign prev_slot  = '0;
      assign prev_prio  = '0;
      assign found_in   = 1'b0;
    end else begin : g_mid
      assign prev_valid = c_valid[i-1];
      assign prev_le    = c_le[i-1];
      assign prev_slot  = c_slot[i-1];
      assign prev_prio  = c_prio[i-1];
      assign found_in   = c_found[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nbr_valid = 1'b0;
      assign nbr_slot  = '0;
      assign nbr_prio  = '0;
    end else begin : g_inner
      assign nbr_valid = c_valid[i+1];
      assign nbr_slot  = c_slot[i+1];
      assign nbr_prio  = c_prio[i+1];
    end

    prq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_valid),
      .prev_le    (prev_le),
      .prev_slot  (prev_slot),
      .prev_prio  (prev_prio),
      .nbr_valid  (nbr_valid),
      .nbr_slot   (nbr_slot),
      .nbr_prio   (nbr_prio),
      .found_in   (found_in),
      .found_out  (c_found[i]),
      .le         (c_le[i]),
      .valid      (c_valid[i]),
      .slot       (c_slot[i]),
      .prio       (c_prio[i]),
      .valid_next (c_valid_next[i]),
      .slot_next  (c_slot_next[i]),
      .prio_next  (c_prio_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      head_valid    <= c_valid_next[0];
      head_slot     <= c_valid_next[0] ? c_slot_next[0] : '0;
      head_priority <= c_valid_next[0] ? c_prio_next[0] : '0;
      op_status     <= status_next;
      entry_count   <= count_ext[COUNT_W-1:0];
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

endmodule

>>> verif/tb_priority_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_ready_queue: self-checking bench for the priority ready queue
// Drives insert, remove, query and unused-opcode requests through the
// valid/stall request channel and predicts the sorted queue in-bench. Each
// response is checked field by field against the oldest prediction. Both
// channels idle at random, and the response side is also held off for a long
// stretch to fill the block and stall its request side.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue;
  import prq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int SLOT_COUNT  = 2 ** SLOT_W;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                head_valid;
    logic [SLOT_W-1:0]   head_slot;
    logic [PRIO_W-1:0]   head_priority;
    logic [STATUS_W-1:0] op_status;
    logic [COUNT_W-1:0]  entry_count;
  } head_report_t;

  logic                clk;
  logic                rst           = 1'b1;
  logic                req_valid     = 1'b0;
  logic                req_stall;
  logic [OP_W-1:0]     opcode        = OP_QUERY;
  logic [SLOT_W-1:0]   slot_id       = '0;
  logic [PRIO_W-1:0]   task_priority = '0;
  logic                rsp_valid;
  logic                rsp_stall     = 1'b0;
  logic                head_valid;
  logic [SLOT_W-1:0]   head_slot;
  logic [PRIO_W-1:0]   head_priority;
  logic [STATUS_W-1:0] op_status;
  logic [COUNT_W-1:0]  entry_count;

  // predicted queue contents, position 0 is the head
  logic [SLOT_W-1:0] ready_slot [QUEUE_DEPTH];
  logic [PRIO_W-1:0] ready_prio [QUEUE_DEPTH];
  bit                is_queued  [SLOT_COUNT];
  int                ready_len = 0;

  head_report_t expected_reports [$];

  bit sender_gaps_on   = 1'b1;
  bit receiver_gaps_on = 1'b1;
  bit rsp_taken        = 1'b0;
  int rsp_hold_req     = 0;
  int mismatch_count   = 0;
  int request_count    = 0;
  int peak_length      = 0;
  int status_seen [4];

  priority_ready_queue #(
    .MAX_ENTRIES(QUEUE_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (opcode),
    .slot_id      (slot_id),
    .task_priority(task_priority),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .head_valid   (head_valid),
    .head_slot    (head_slot),
    .head_priority(head_priority),
    .op_status    (op_status),
    .entry_count  (entry_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic head_report_t advance_ready_queue(input logic [OP_W-1:0] op,
                                                       input logic [SLOT_W-1:0] slot,
                                                       input logic [PRIO_W-1:0] prio);
    head_report_t r;
    int i;
    int pos;
    r = '0;
    r.op_status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (is_queued[slot]) begin
          r.op_status = ST_DUPLICATE;
        end else if (ready_len < QUEUE_DEPTH) begin
          pos = 0;
          while (pos < ready_len && ready_prio[pos] <= prio) pos++;
          for (i = ready_len; i > pos; i--) begin
            ready_slot[i] = ready_slot[i-1];
            ready_prio[i] = ready_prio[i-1];
          end
          ready_slot[pos] = slot;
          ready_prio[pos] = prio;
          is_queued[slot] = 1'b1;
          ready_len++;
        end
      end
      OP_REMOVE: begin
        if (ready_len == 0) begin
          r.op_status = ST_EMPTY;
        end else if (!is_queued[slot]) begin
          r.op_status = ST_NOT_FOUND;
        end else begin
          pos = 0;
          while (ready_slot[pos] != slot) pos++;
          for (i = pos; i + 1 < ready_len; i++) begin
            ready_slot[i] = ready_slot[i+1];
            ready_prio[i] = ready_prio[i+1];
          end
          is_queued[slot] = 1'b0;
          ready_len--;
        end
      end
      default: ;
    endcase
    if (ready_len > 0) begin
      r.head_valid    = 1'b1;
      r.head_slot     = ready_slot[0];
      r.head_priority = ready_prio[0];
    end
    r.entry_count = COUNT_W'(ready_len);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_absent_slot();
    logic [SLOT_W-1:0] s;
    do s = SLOT_W'($urandom_range(0, SLOT_COUNT - 1)); while (is_queued[s]);
    return s;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_queued_slot();
    return ready_slot[$urandom_range(0, ready_len - 1)];
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                              input logic [PRIO_W-1:0] prio);
    int gap;
    head_report_t r;
    gap = sender_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid     <= 1'b1;
    opcode        <= op;
    slot_id       <= slot;
    task_priority <= prio;
    do @(posedge clk); while (req_stall);
    r = advance_ready_queue(op, slot, prio);
    expected_reports.push_back(r);
    request_count++;
    status_seen[r.op_status]++;
    if (ready_len > peak_length) peak_length = ready_len;
  endtask

  task automatic wait_for_reports();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(input string field_name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field_name, want, got);
    end
  endtask

  // check each accepted response against the oldest prediction
  always @(posedge clk) begin
    head_report_t want;
    rsp_taken = 1'b0;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_taken = 1'b1;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected response, expected none actual status %0d", $time,
                 op_status);
      end else begin
        want = expected_reports.pop_front();
        compare_field("head_valid", want.head_valid, head_valid);
        compare_field("head_slot", want.head_slot, head_slot);
        compare_field("head_priority", want.head_priority, head_priority);
        compare_field("op_status", want.op_status, op_status);
        compare_field("entry_count", want.entry_count, entry_count);
      end
    end
  end

  // response side: random stall per response, plus long holds on request
  always @(negedge clk) begin
    int hold_left;
    int stall_left;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (rsp_hold_req > 0) begin
        hold_left    = rsp_hold_req;
        rsp_hold_req = 0;
      end
      if (rsp_taken) stall_left = receiver_gaps_on ? $urandom_range(0, 3) : 0;
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed_cases();
    send_request(OP_QUERY, 6'd0, 3'd0);
    send_request(OP_REMOVE, 6'd0, 3'd0);
    send_request(OP_UNUSED, 6'd63, 3'd7);
    send_request(OP_INSERT, 6'd63, 3'd7);
    send_request(OP_INSERT, 6'd0, 3'd0);
    send_request(OP_INSERT, 6'd21, 3'd7);
    send_request(OP_INSERT, 6'd42, 3'd0);
    send_request(OP_INSERT, 6'd63, 3'd3);
    send_request(OP_REMOVE, 6'd10, 3'd5);
    send_request(OP_REMOVE, 6'd63, 3'd0);
    send_request(OP_QUERY, 6'd63, 3'd7);
    send_request(OP_REMOVE, 6'd0, 3'd0);
    send_request(OP_INSERT, 6'd0, 3'd4);
    send_request(OP_UNUSED, 6'd0, 3'd0);
    send_request(OP_REMOVE, 6'd42, 3'd0);
    send_request(OP_REMOVE, 6'd0, 3'd0);
    send_request(OP_REMOVE, 6'd21, 3'd0);
    send_request(OP_REMOVE, 6'd21, 3'd0);
    send_request(OP_INSERT, 6'd5, 3'd7);
    send_request(OP_INSERT, 6'd6, 3'd0);
    send_request(OP_REMOVE, 6'd6, 3'd0);
    send_request(OP_REMOVE, 6'd5, 3'd0);
    wait_for_reports();
  endtask

  task automatic test_fill_and_drain();
    int order [SLOT_COUNT];
    int i;
    int j;
    int tmp;
    for (i = 0; i < SLOT_COUNT; i++) order[i] = i;
    for (i = SLOT_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (i = 0; i < SLOT_COUNT; i++)
      send_request(OP_INSERT, SLOT_W'(order[i]), PRIO_W'($urandom_range(0, 7)));
    send_request(OP_INSERT, SLOT_W'(order[0]), PRIO_W'($urandom_range(0, 7)));
    send_request(OP_QUERY, SLOT_W'($urandom), PRIO_W'($urandom));
    for (i = SLOT_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (i = 0; i < SLOT_COUNT; i++)
      send_request(OP_REMOVE, SLOT_W'(order[i]), PRIO_W'($urandom));
    send_request(OP_REMOVE, SLOT_W'($urandom), PRIO_W'($urandom));
    wait_for_reports();
  endtask

  task automatic test_output_backpressure();
    int k;
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    rsp_hold_req     = 48;
    for (k = 0; k < 40; k++) begin
      if (ready_len < QUEUE_DEPTH && k % 4 != 3)
        send_request(OP_INSERT, pick_absent_slot(), PRIO_W'($urandom_range(0, 7)));
      else
        send_request(OP_REMOVE, pick_queued_slot(), PRIO_W'($urandom));
    end
    wait_for_reports();
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
  endtask

  task automatic test_random_mix(input int n_items);
    int k;
    int roll;
    int target;
    int prio_hi;
    bit do_insert;
    logic [SLOT_W-1:0] s;
    logic [PRIO_W-1:0] p;
    target  = 8;
    prio_hi = 7;
    for (k = 0; k < n_items; k++) begin
      if (k % 120 == 0) begin
        // pause until the queue of predictions has drained, then reshape
        wait_for_reports();
        case ($urandom_range(0, 3))
          0:       target = 3;
          1:       target = 16;
          2:       target = 40;
          default: target = QUEUE_DEPTH;
        endcase
        prio_hi          = $urandom_range(0, 1) ? 7 : 1;
        sender_gaps_on   = $urandom_range(0, 2) != 0;
        receiver_gaps_on = $urandom_range(0, 2) != 0;
      end
      roll = $urandom_range(0, 99);
      s    = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      p    = PRIO_W'($urandom_range(0, prio_hi));
      if (roll < 6) begin
        send_request(OP_QUERY, s, p);
      end else if (roll < 8) begin
        send_request(OP_UNUSED, s, p);
      end else begin
        do_insert = ($urandom_range(0, 99) < (ready_len < target ? 75 : 30));
        if (do_insert) begin
          if (ready_len < QUEUE_DEPTH && $urandom_range(0, 99) < 85) s = pick_absent_slot();
          send_request(OP_INSERT, s, p);
        end else begin
          if (ready_len > 0 && $urandom_range(0, 99) < 85) s = pick_queued_slot();
          send_request(OP_REMOVE, s, PRIO_W'($urandom));
        end
      end
    end
    wait_for_reports();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_mix(1060);
    $display("Sent %0d requests: %0d ok, %0d remove on empty, %0d absent, %0d duplicate",
             request_count, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_NOT_FOUND], status_seen[ST_DUPLICATE]);
    $display("Deepest queue %0d entries, with long response hold and drain pauses",
             peak_length);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
